>>> rtl/circular_fifo_with_positional_delete_assert.svh
// Assertion macros used by the checker of the circular FIFO block.
// Depends on nothing; included by the checker file.
`ifndef CIRCULAR_FIFO_WITH_POSITIONAL_DELETE_ASSERT_SVH
`define CIRCULAR_FIFO_WITH_POSITIONAL_DELETE_ASSERT_SVH

// Clocked assertion that is switched off while reset is active.
`define CFPD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define CFPD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/cfpd_pkg.sv
// Package of the circular FIFO with positional delete: sizes, the mode code
// and the command and status structs between controller and datapath.
// Depends on nothing.
package cfpd_pkg;

	localparam int DEPTH  = 128;
	localparam int DATA_W = 32;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int POS_W  = 7;

	typedef enum logic [1:0] {
		MODE_ENQ  = 2'd0,
		MODE_DEQ  = 2'd1,
		MODE_DEL  = 2'd2,
		MODE_STAT = 2'd3
	} mode_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;     // capture the incoming request
		logic exec;     // apply the operation to the pointers
		logic shift;    // move one entry toward the head
		logic head_rd;  // read the word at the head
		logic resp;     // load the response register
	} cfpd_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_shift;  // the delete leaves entries to move
		logic shift_more;  // another entry follows the one moved now
	} cfpd_stat_t;

endpackage

>>> rtl/cfpd_in_if.sv
// Request channel of the circular FIFO: valid, ready and the request fields.
// Depends on cfpd_pkg.
interface cfpd_in_if;
	import cfpd_pkg::*;

	logic                     valid;
	logic                     ready;
	mode_t                    mode;
	logic signed [DATA_W-1:0] value;
	logic [POS_W-1:0]         position;

	modport source (output valid, output mode, output value, output position, input ready);
	modport sink (input valid, input mode, input value, input position, output ready);

endinterface

>>> rtl/cfpd_out_if.sv
// Response channel of the circular FIFO: valid, ready and the response fields.
// Depends on cfpd_pkg.
interface cfpd_out_if;
	import cfpd_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     accepted;
	logic signed [DATA_W-1:0] head_value;
	logic                     is_empty;
	logic                     is_full;
	logic [CNT_W-1:0]         occupancy;

	modport source (output valid, output accepted, output head_value, output is_empty,
		output is_full, output occupancy, input ready);
	modport sink (input valid, input accepted, input head_value, input is_empty,
		input is_full, input occupancy, output ready);

endinterface

>>> rtl/cfpd_datapath.sv
// Datapath of the circular FIFO: word memory, head, tail and count registers,
// shift index and the response register. Depends on cfpd_pkg.
module cfpd_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cfpd_pkg::cfpd_cmd_t               cmd,
	output cfpd_pkg::cfpd_stat_t              stat,
	input  cfpd_pkg::mode_t                   in_mode,
	input  logic signed [cfpd_pkg::DATA_W-1:0] in_value,
	input  logic [cfpd_pkg::POS_W-1:0]        in_position,
	output logic                              accepted,
	output logic signed [cfpd_pkg::DATA_W-1:0] head_value,
	output logic                              is_empty,
	output logic                              is_full,
	output logic [cfpd_pkg::CNT_W-1:0]        occupancy
);
	import cfpd_pkg::*;

	// Slot arithmetic around the ring; the offset never exceeds DEPTH.
	function automatic logic [IDX_W-1:0] slot_add(input logic [IDX_W-1:0] base,
		input logic [IDX_W:0] offs);
		logic [IDX_W+1:0] sum;
		sum = (IDX_W+2)'(base) + (IDX_W+2)'(offs);
		if (sum >= (IDX_W+2)'(DEPTH)) begin
			sum = sum - (IDX_W+2)'(DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

	logic [DATA_W-1:0] mem [DEPTH];

	logic [IDX_W-1:0]  head_q;
	logic [IDX_W-1:0]  tail_q;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  k_q;
	mode_t             mode_q;
	logic [DATA_W-1:0] value_q;
	logic [POS_W-1:0]  pos_q;
	logic              acc_q;
	logic [DATA_W-1:0] rd_data_q;

	logic              rsp_acc_q;
	logic [DATA_W-1:0] rsp_head_q;
	logic              rsp_empty_q;
	logic              rsp_full_q;
	logic [CNT_W-1:0]  rsp_count_q;

	logic             do_enq;
	logic             do_deq;
	logic             do_del;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [DATA_W-1:0] wr_data;

	// Decide what the captured request does to the queue.
	always_comb begin
		do_enq = (mode_q == MODE_ENQ) && (count_q < CNT_W'(DEPTH));
		do_deq = (mode_q == MODE_DEQ) && (count_q != '0);
		do_del = (mode_q == MODE_DEL) && (count_q != '0) && (CNT_W'(pos_q) < count_q);
		stat.need_shift = do_del && ((CNT_W'(pos_q) + CNT_W'(1)) < count_q);
		// The count is already reduced while entries move.
		stat.shift_more = (CNT_W'(k_q) + CNT_W'(1)) < count_q;
	end

	// Memory port selection: one read and one write per cycle.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = head_q;
		if (cmd.exec) begin
			rd_en   = stat.need_shift;
			rd_addr = slot_add(head_q, (IDX_W+1)'(pos_q) + (IDX_W+1)'(1));
		end else if (cmd.shift) begin
			rd_en   = stat.shift_more;
			rd_addr = slot_add(head_q, (IDX_W+1)'(k_q) + (IDX_W+1)'(2));
		end else if (cmd.head_rd) begin
			rd_en   = 1'b1;
			rd_addr = head_q;
		end
		wr_en   = 1'b0;
		wr_addr = tail_q;
		wr_data = value_q;
		if (cmd.exec && do_enq) begin
			wr_en = 1'b1;
		end else if (cmd.shift) begin
			wr_en   = 1'b1;
			wr_addr = slot_add(head_q, (IDX_W+1)'(k_q));
			wr_data = rd_data_q;
		end
	end

	// Word memory with registered read data.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Queue pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (cmd.exec) begin
			if (do_enq) begin
				tail_q  <= slot_add(tail_q, (IDX_W+1)'(1));
				count_q <= count_q + CNT_W'(1);
			end else if (do_deq) begin
				head_q  <= slot_add(head_q, (IDX_W+1)'(1));
				count_q <= count_q - CNT_W'(1);
			end else if (do_del) begin
				tail_q  <= slot_add(tail_q, (IDX_W+1)'(DEPTH - 1));
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Captured request, shift index and response payload.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= in_mode;
			value_q <= in_value;
			pos_q   <= in_position;
		end
		if (cmd.exec) begin
			acc_q <= do_enq || do_deq || do_del;
			k_q   <= IDX_W'(pos_q);
		end else if (cmd.shift) begin
			k_q <= k_q + IDX_W'(1);
		end
		if (cmd.resp) begin
			rsp_acc_q   <= acc_q;
			rsp_head_q  <= (count_q == '0) ? '1 : rd_data_q;
			rsp_empty_q <= (count_q == '0);
			rsp_full_q  <= (count_q == CNT_W'(DEPTH));
			rsp_count_q <= count_q;
		end
	end

	assign accepted   = rsp_acc_q;
	assign head_value = rsp_head_q;
	assign is_empty   = rsp_empty_q;
	assign is_full    = rsp_full_q;
	assign occupancy  = rsp_count_q;

endmodule

>>> rtl/cfpd_ctrl.sv
// Controller of the circular FIFO: sequences capture, update, entry shift,
// head read and response. Depends on cfpd_pkg.
module cfpd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output cfpd_pkg::cfpd_cmd_t  cmd,
	input  cfpd_pkg::cfpd_stat_t stat
);
	import cfpd_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SHIFT,
		S_HEAD,
		S_RESP
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	// The response register can take a new response when empty or draining.
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Commands follow the state.
	always_comb begin
		cmd.load    = (state_q == S_IDLE) && in_valid;
		cmd.exec    = (state_q == S_EXEC);
		cmd.shift   = (state_q == S_SHIFT);
		cmd.head_rd = (state_q == S_HEAD);
		cmd.resp    = (state_q == S_RESP) && out_free;
	end

	// State and response valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.resp) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= stat.need_shift ? S_SHIFT : S_HEAD;
				end
				S_SHIFT: begin
					if (!stat.shift_more) begin
						state_q <= S_HEAD;
					end
				end
				S_HEAD: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/circular_fifo_with_positional_delete.sv
// Circular FIFO of signed words with enqueue, dequeue, delete at an offset
// from the head, and a status-only request; every request returns one response
// with the accepted flag, the head word (all ones when empty), the empty and
// full flags and the occupancy. A request passes through capture, pointer
// update, head read and response load; a delete at offset p of a queue
// holding n entries also moves each of the n - p - 1 later entries toward
// the head through the single read and write port of the word memory. One
// request is in work at a time; the next is accepted once the response is
// loaded, even while it still waits to be taken.
// Depends on cfpd_pkg, cfpd_in_if, cfpd_out_if, cfpd_ctrl and cfpd_datapath.
module circular_fifo_with_positional_delete (
	input logic        clk,
	input logic        arst_n,
	cfpd_in_if.sink    item,
	cfpd_out_if.source result
);
	import cfpd_pkg::*;

	cfpd_cmd_t  cmd;
	cfpd_stat_t stat;

	// Sequencer.
	cfpd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// Storage and pointers.
	cfpd_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.in_mode     (item.mode),
		.in_value    (item.value),
		.in_position (item.position),
		.accepted    (result.accepted),
		.head_value  (result.head_value),
		.is_empty    (result.is_empty),
		.is_full     (result.is_full),
		.occupancy   (result.occupancy)
	);

endmodule

>>> rtl/cfpd_checker.sv
// Port-level checks of the circular FIFO and the bind that attaches them.
// Depends on cfpd_pkg and the assertion macro header.
`include "circular_fifo_with_positional_delete_assert.svh"

module cfpd_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               res_valid,
	input logic                               res_ready,
	input logic signed [cfpd_pkg::DATA_W-1:0] res_head,
	input logic                               res_empty,
	input logic                               res_full,
	input logic [cfpd_pkg::CNT_W-1:0]         res_count
);
	import cfpd_pkg::*;

	// The flags agree with the occupancy.
	`CFPD_ASSERT(a_empty_flag, clk, arst_n, res_valid |-> (res_empty == (res_count == '0)), "empty flag disagrees with occupancy")
	`CFPD_ASSERT(a_full_flag, clk, arst_n, res_valid |-> (res_full == (res_count == CNT_W'(DEPTH))), "full flag disagrees with occupancy")

	// An empty queue reports all ones as its head word.
	`CFPD_ASSERT(a_empty_head, clk, arst_n, (res_valid && res_empty) |-> (res_head == '1), "empty queue reports a head word")

	// A stalled response keeps its occupancy.
	`CFPD_ASSERT(a_hold, clk, arst_n, (res_valid && !res_ready) |=> (res_valid && $stable(res_count)), "stalled response changed")

	// No response while reset is applied.
	`CFPD_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !res_valid, "response valid during reset")

endmodule

bind circular_fifo_with_positional_delete cfpd_checker u_cfpd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_head  (result.head_value),
	.res_empty (result.is_empty),
	.res_full  (result.is_full),
	.res_count (result.occupancy)
);

>>> dv/cfpd_scoreboard_pkg.sv
// Scoreboard for the circular FIFO with positional delete: a queue model of
// the contents and the store of predicted responses, one per request.
// Depends on cfpd_pkg.
package cfpd_scoreboard_pkg;
	import cfpd_pkg::*;

	// One response as the block reports it.
	typedef struct packed {
		logic              accepted;
		logic [DATA_W-1:0] head_value;
		logic              is_empty;
		logic              is_full;
		logic [CNT_W-1:0]  occupancy;
	} fifo_status_t;

	class fifo_scoreboard;
		localparam int MAX_REPORTS = 10;

		// Contents of the FIFO, oldest word first.
		logic [DATA_W-1:0] words[$];
		// Predicted responses, oldest first.
		fifo_status_t      predicted[$];

		int mismatches;
		int checked;
		int n_enq;
		int n_deq;
		int n_del;
		int n_stat;
		int n_ignored;
		int n_full;
		int deepest_delete;

		function new();
			mismatches     = 0;
			checked        = 0;
			n_enq          = 0;
			n_deq          = 0;
			n_del          = 0;
			n_stat         = 0;
			n_ignored      = 0;
			n_full         = 0;
			deepest_delete = 0;
		endfunction

		function int held();
			return words.size();
		endfunction

		function int outstanding();
			return predicted.size();
		endfunction

		// Apply an accepted request to the model and queue its response.
		function void note_request(mode_t mode, logic [DATA_W-1:0] value,
				logic [POS_W-1:0] position);
			fifo_status_t want;
			logic         changed;
			changed = 1'b0;
			case (mode)
				MODE_ENQ: begin
					n_enq++;
					if (words.size() < DEPTH) begin
						words.push_back(value);
						changed = 1'b1;
					end
				end
				MODE_DEQ: begin
					n_deq++;
					if (words.size() != 0) begin
						void'(words.pop_front());
						changed = 1'b1;
					end
				end
				MODE_DEL: begin
					n_del++;
					if (int'(position) < words.size()) begin
						// Later entries close the gap toward the head.
						if (words.size() - int'(position) - 1 > deepest_delete)
							deepest_delete = words.size() - int'(position) - 1;
						words.delete(int'(position));
						changed = 1'b1;
					end
				end
				default: begin
					n_stat++;
				end
			endcase
			if (!changed)
				n_ignored++;
			want.accepted   = changed;
			want.head_value = (words.size() != 0) ? words[0] : {DATA_W{1'b1}};
			want.is_empty   = (words.size() == 0);
			want.is_full    = (words.size() == DEPTH);
			want.occupancy  = CNT_W'(words.size());
			if (want.is_full)
				n_full++;
			predicted.push_back(want);
		endfunction

		// Compare a taken response with the oldest prediction.
		function void check_response(fifo_status_t got);
			fifo_status_t want;
			string        bad;
			if (predicted.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("ERROR: response with no request pending: accepted=%0b head=%0d",
						got.accepted, $signed(got.head_value));
				return;
			end
			want = predicted.pop_front();
			checked++;
			bad = "";
			if (got.accepted !== want.accepted)
				bad = {bad, " accepted"};
			if (got.head_value !== want.head_value)
				bad = {bad, " head_value"};
			if (got.is_empty !== want.is_empty)
				bad = {bad, " is_empty"};
			if (got.is_full !== want.is_full)
				bad = {bad, " is_full"};
			if (got.occupancy !== want.occupancy)
				bad = {bad, " occupancy"};
			if (bad != "") begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("ERROR: response %0d wrong in%s", checked, bad);
					$display("  expected accepted=%0b head=%0d empty=%0b full=%0b count=%0d",
						want.accepted, $signed(want.head_value), want.is_empty,
						want.is_full, want.occupancy);
					$display("  actual   accepted=%0b head=%0d empty=%0b full=%0b count=%0d",
						got.accepted, $signed(got.head_value), got.is_empty,
						got.is_full, got.occupancy);
				end
			end
		endfunction
	endclass

endpackage

>>> dv/testbench.sv
// Top-level testbench of circular_fifo_with_positional_delete: drives
// requests, stalls responses and checks each one against the scoreboard.
// Depends on cfpd_pkg, cfpd_in_if, cfpd_out_if and cfpd_scoreboard_pkg.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import cfpd_pkg::*;
	import cfpd_scoreboard_pkg::*;

	localparam int HOLD_CYCLES  = 300;
	localparam int QUIET_LIMIT  = 4000;
	localparam int SETTLE_CYCLES = 16;

	logic clk = 1'b0;
	logic arst_n;

	cfpd_in_if  req_if ();
	cfpd_out_if rsp_if ();

	circular_fifo_with_positional_delete dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (req_if),
		.result (rsp_if)
	);

	fifo_scoreboard sb;

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int hold_token    = 0;
	int hold_seen     = 0;
	int hold_left     = 0;
	int quiet_cycles  = 0;
	int sent          = 0;

	// Clock with an 8 ns period.
	always #4 clk = ~clk;

	// Offer one request after a random gap and wait until it is taken.
	task automatic send_request(mode_t mode, logic [DATA_W-1:0] value,
			logic [POS_W-1:0] position);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid    <= 1'b1;
		req_if.mode     <= mode;
		req_if.value    <= value;
		req_if.position <= position;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		sb.note_request(mode, value, position);
		sent++;
	endtask

	// Random word, with the extremes mixed in now and then.
	function automatic logic [DATA_W-1:0] random_word();
		case ($urandom_range(0, 19))
			0: return {1'b1, {(DATA_W-1){1'b0}}};
			1: return {1'b0, {(DATA_W-1){1'b1}}};
			2: return {DATA_W{1'b1}};
			3: return '0;
			default: return $urandom;
		endcase
	endfunction

	// Offset for a request: a held entry unless the spread_pct draw picks anything.
	function automatic logic [POS_W-1:0] pick_position(int spread_pct);
		if (sb.held() != 0 && $urandom_range(0, 99) >= spread_pct)
			return POS_W'($urandom_range(0, sb.held() - 1));
		return POS_W'($urandom_range(0, (1 << POS_W) - 1));
	endfunction

	// Random traffic built from fill bursts, drain bursts and mixed runs.
	task automatic run_random(int count);
		int left;
		int len;
		int kind;
		int pick;
		int i;
		left = count;
		while (left > 0) begin
			kind = $urandom_range(0, 99);
			if (kind < 35)
				len = $urandom_range(8, 140);
			else if (kind < 65)
				len = $urandom_range(4, sb.held() + 4);
			else
				len = $urandom_range(10, 30);
			if (len > left)
				len = left;
			for (i = 0; i < len; i++) begin
				pick = $urandom_range(0, 99);
				if (kind < 35) begin
					if (pick < 90)
						send_request(MODE_ENQ, random_word(), pick_position(100));
					else
						send_request(MODE_STAT, random_word(), pick_position(100));
				end else if (kind < 65) begin
					if (pick < 55)
						send_request(MODE_DEL, random_word(), pick_position(15));
					else if (pick < 90)
						send_request(MODE_DEQ, random_word(), pick_position(100));
					else
						send_request(MODE_STAT, random_word(), pick_position(100));
				end else begin
					send_request(mode_t'($urandom_range(0, 3)), random_word(),
						pick_position(30));
				end
			end
			left -= len;
		end
	endtask

	// Response side: random stalls, the long hold-off, checking and watchdog.
	always @(posedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen      <= hold_token;
			hold_left      <= HOLD_CYCLES;
			rsp_if.ready   <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left      <= hold_left - 1;
			rsp_if.ready   <= 1'b0;
		end else begin
			rsp_if.ready   <= ($urandom_range(0, 99) >= stall_pct);
		end

		if (arst_n && rsp_if.valid && rsp_if.ready)
			sb.check_response({rsp_if.accepted, rsp_if.head_value, rsp_if.is_empty,
				rsp_if.is_full, rsp_if.occupancy});

		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;

		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("ERROR: no request or response moved for %0d cycles", QUIET_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Stimulus: reset, directed cases, then random traffic in idling phases.
	initial begin
		sb = new();
		req_if.valid    <= 1'b0;
		req_if.mode     <= MODE_STAT;
		req_if.value    <= '0;
		req_if.position <= '0;
		arst_n          <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty queue: status, dequeue and delete are all ignored.
		send_request(MODE_STAT, 32'h0000_0000, 7'd0);
		send_request(MODE_DEQ, 32'hDEAD_BEEF, 7'd0);
		send_request(MODE_DEL, 32'h1234_5678, 7'd0);
		// Extreme words.
		send_request(MODE_ENQ, 32'h8000_0000, 7'd0);
		send_request(MODE_ENQ, 32'h7FFF_FFFF, 7'd127);
		send_request(MODE_ENQ, 32'hFFFF_FFFF, 7'd0);
		send_request(MODE_ENQ, 32'h0000_0000, 7'd0);
		send_request(MODE_STAT, 32'h5555_5555, 7'd127);
		// Delete at the occupancy and at the largest offset: out of range.
		send_request(MODE_DEL, 32'h0, 7'd4);
		send_request(MODE_DEL, 32'h0, 7'd127);
		// Delete the last entry, then the head, then one in the middle.
		send_request(MODE_DEL, 32'h0, 7'd3);
		send_request(MODE_DEL, 32'h0, 7'd0);
		send_request(MODE_ENQ, 32'h1234_5678, 7'd0);
		send_request(MODE_ENQ, 32'hA5A5_A5A5, 7'd0);
		send_request(MODE_DEL, 32'h0, 7'd1);
		// Drain to empty, then one dequeue too many.
		send_request(MODE_DEQ, 32'h0, 7'd0);
		send_request(MODE_DEQ, 32'h0, 7'd0);
		send_request(MODE_DEQ, 32'h0, 7'd0);
		send_request(MODE_DEQ, 32'h0, 7'd0);
		send_request(MODE_STAT, 32'h0, 7'd0);

		// No idling; fill past full first so enqueue on a full queue is hit.
		repeat (DEPTH + 4)
			send_request(MODE_ENQ, random_word(), pick_position(100));
		run_random(100);

		// Sender idles about half the time.
		send_idle_pct = 52;
		run_random(100);

		// Receiver stalls about half the time.
		send_idle_pct = 0;
		stall_pct     <= 52;
		run_random(100);

		// Both sides idle.
		send_idle_pct = 30;
		stall_pct     <= 30;
		run_random(100);

		// Long receiver hold-off while requests keep coming.
		send_idle_pct = 0;
		stall_pct     <= 0;
		hold_token    <= hold_token + 1;
		run_random(100);

		req_if.valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Checked %0d responses for %0d requests: %0d enqueue, %0d dequeue, %0d delete,",
			sb.checked, sent, sb.n_enq, sb.n_deq, sb.n_del);
		$display("%0d status; %0d ignored, %0d left the queue full, longest shift %0d entries.",
			sb.n_stat, sb.n_ignored, sb.n_full, sb.deepest_delete);
		if (sb.mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", sb.mismatches);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
